// ===== design/signed_decimal_field_formatter_core_defines.svh =====
// assertion macros shared by the formatter rtl
`ifndef SIGNED_DECIMAL_FIELD_FORMATTER_CORE_DEFINES_SVH
`define SIGNED_DECIMAL_FIELD_FORMATTER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define SDFF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define SDFF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/sdff_pkg.sv =====
// types, constants and microcode table of the decimal field formatter
`timescale 1ns / 1ps

package sdff_pkg;

	localparam int MAX_FIELD_WIDTH_DEF = 63;
	localparam int MAX_RESULTS = 64;
	localparam int NDIG_MAX = 10;
	localparam int PC_W = 4;

	localparam logic [31:0] RECIP10 = 32'hCCCCCCCD;
	localparam int RECIP_SHIFT = 35;

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_DIVM,
		OP_DIVR,
		OP_PREP,
		OP_CNT1,
		OP_CNT2,
		OP_TOT,
		OP_EMIT,
		OP_FIN
	} op_t;

	typedef enum logic [2:0] {
		SRC_SPACE,
		SRC_LEAD,
		SRC_SIGN,
		SRC_ZERO,
		SRC_DIGIT,
		SRC_TRAIL
	} src_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_NO_IN,
		COND_MORE_DIG,
		COND_RUN,
		COND_FIN_WAIT
	} cond_t;

	typedef struct packed {
		op_t op;
		src_t src;
		src_t ld;
		cond_t cond;
		logic [PC_W-1:0] jt;
		logic [PC_W-1:0] jf;
	} ucode_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic rem;
	} dcmd_t;

	localparam logic [PC_W-1:0] PC_IDLE = 4'd0;
	localparam logic [PC_W-1:0] PC_DIVM = 4'd1;
	localparam logic [PC_W-1:0] PC_DIVR = 4'd2;
	localparam logic [PC_W-1:0] PC_PREP = 4'd3;
	localparam logic [PC_W-1:0] PC_CNT1 = 4'd4;
	localparam logic [PC_W-1:0] PC_CNT2 = 4'd5;
	localparam logic [PC_W-1:0] PC_TOT = 4'd6;
	localparam logic [PC_W-1:0] PC_E_SPACE = 4'd7;
	localparam logic [PC_W-1:0] PC_E_LEAD = 4'd8;
	localparam logic [PC_W-1:0] PC_E_SIGN = 4'd9;
	localparam logic [PC_W-1:0] PC_E_ZERO = 4'd10;
	localparam logic [PC_W-1:0] PC_E_DIGIT = 4'd11;
	localparam logic [PC_W-1:0] PC_E_TRAIL = 4'd12;
	localparam logic [PC_W-1:0] PC_FIN = 4'd13;

	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		w = '{OP_IDLE, SRC_SPACE, SRC_SPACE, COND_NO_IN, PC_IDLE, PC_DIVM};
		case (pc)
			PC_IDLE: w = '{OP_IDLE, SRC_SPACE, SRC_SPACE, COND_NO_IN, PC_IDLE, PC_DIVM};
			PC_DIVM: w = '{OP_DIVM, SRC_SPACE, SRC_SPACE, COND_NEVER, PC_DIVM, PC_DIVR};
			PC_DIVR: w = '{OP_DIVR, SRC_SPACE, SRC_SPACE, COND_MORE_DIG, PC_DIVM, PC_PREP};
			PC_PREP: w = '{OP_PREP, SRC_SPACE, SRC_SPACE, COND_NEVER, PC_PREP, PC_CNT1};
			PC_CNT1: w = '{OP_CNT1, SRC_SPACE, SRC_SPACE, COND_NEVER, PC_CNT1, PC_CNT2};
			PC_CNT2: w = '{OP_CNT2, SRC_SPACE, SRC_SPACE, COND_NEVER, PC_CNT2, PC_TOT};
			PC_TOT: w = '{OP_TOT, SRC_SPACE, SRC_SPACE, COND_NEVER, PC_TOT, PC_E_SPACE};
			PC_E_SPACE: w = '{OP_EMIT, SRC_SPACE, SRC_LEAD, COND_RUN, PC_E_SPACE, PC_E_LEAD};
			PC_E_LEAD: w = '{OP_EMIT, SRC_LEAD, SRC_SIGN, COND_RUN, PC_E_LEAD, PC_E_SIGN};
			PC_E_SIGN: w = '{OP_EMIT, SRC_SIGN, SRC_ZERO, COND_RUN, PC_E_SIGN, PC_E_ZERO};
			PC_E_ZERO: w = '{OP_EMIT, SRC_ZERO, SRC_DIGIT, COND_RUN, PC_E_ZERO, PC_E_DIGIT};
			PC_E_DIGIT: w = '{OP_EMIT, SRC_DIGIT, SRC_TRAIL, COND_RUN, PC_E_DIGIT, PC_E_TRAIL};
			PC_E_TRAIL: w = '{OP_EMIT, SRC_TRAIL, SRC_SPACE, COND_RUN, PC_E_TRAIL, PC_FIN};
			PC_FIN: w = '{OP_FIN, SRC_SPACE, SRC_SPACE, COND_FIN_WAIT, PC_FIN, PC_IDLE};
			default: w = '{OP_IDLE, SRC_SPACE, SRC_SPACE, COND_NO_IN, PC_IDLE, PC_DIVM};
		endcase
		return w;
	endfunction

endpackage

// ===== design/sdff_digits.sv =====
// decimal digit extraction by reciprocal multiply, with the digit store
`timescale 1ns / 1ps

module sdff_digits (
	input logic clk,
	input logic arst_n,
	input sdff_pkg::dcmd_t cmd,
	input logic signed [31:0] value,
	input logic [3:0] rd_idx,
	output logic [3:0] ndig,
	output logic more,
	output logic [3:0] rd_digit
);
	import sdff_pkg::*;

	logic [31:0] m_q;
	logic [31:0] q_q;
	logic [3:0] ndig_q;
	logic [3:0] digs_q [NDIG_MAX];
	logic [63:0] prod;
	logic [3:0] q10;
	logic [3:0] rem_d;

	assign prod = m_q * RECIP10;
	// only the low nibble of 10*q is needed, the remainder stays below ten
	assign q10 = {q_q[0], 3'b000} + {q_q[2:0], 1'b0};
	assign rem_d = m_q[3:0] - q10;

	assign ndig = ndig_q;
	assign more = (q_q != 32'd0) && (ndig_q < 4'(NDIG_MAX - 1));
	assign rd_digit = digs_q[rd_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ndig_q <= '0;
		end else if (cmd.load) begin
			ndig_q <= '0;
		end else if (cmd.rem) begin
			ndig_q <= ndig_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_q <= value[31] ? (32'd0 - $unsigned(value)) : $unsigned(value);
		end else if (cmd.rem) begin
			m_q <= q_q;
			digs_q[ndig_q] <= rem_d;
		end
		if (cmd.mul) begin
			q_q <= 32'(prod >> RECIP_SHIFT);
		end
	end

endmodule

// ===== design/signed_decimal_field_formatter_core.sv =====
// Formats one signed 32-bit value as printf %d text, one ASCII character per output
// transfer. An item runs through a small microcoded sequencer: an accept state, a
// multiply and a remainder state per decimal digit in the divide-by-ten unit (1 to 10
// digits), the PREP, CNT1, CNT2 and TOT states that work out the lengths of the blank,
// sign, zero, digit and trailing-blank runs, then an emit state for each of the six runs,
// which steps once per character and closes the run, and a final state. The output
// register takes one character per cycle while out_stall is low. The last character
// carries is_last and the character count; an item with no text gives a single transfer
// with is_empty set. The input is taken only while the sequencer is idle.
`timescale 1ns / 1ps
`include "signed_decimal_field_formatter_core_defines.svh"

module signed_decimal_field_formatter_core #(
	parameter int MAX_FIELD_WIDTH = sdff_pkg::MAX_FIELD_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic signed [31:0] value,
	input logic [5:0] field_width,
	input logic signed [6:0] precision,
	input logic flag_left_align,
	input logic flag_zero_pad,
	input logic flag_plus,
	input logic flag_space,
	output logic out_valid,
	input logic out_stall,
	output logic [7:0] character,
	output logic is_last,
	output logic is_empty,
	output logic [6:0] char_count
);
	import sdff_pkg::*;

	logic [PC_W-1:0] pc_q;
	ucode_t uc;
	logic in_acc;
	logic slot_free;
	logic taken;

	logic neg_q, vz_q, left_q, zero_q, plus_q, space_q;
	logic [5:0] wcl_q;
	logic [5:0] wcl_d;
	logic signed [6:0] prec_q;

	logic signed [8:0] w_q, d_q;
	logic len_nz_q, sp_q;
	logic [6:0] lead_q, zc_q, trail_q;
	logic [6:0] cap_q, n_q, run_q;

	logic out_valid_q, out_last_q, out_empty_q;
	logic [7:0] out_char_q;
	logic [6:0] out_cnt_q;

	dcmd_t dcmd;
	logic [3:0] ndig;
	logic more;
	logic [3:0] rd_idx;
	logic [3:0] rd_digit;

	logic pz, pinc, signc;
	logic signed [8:0] len_s, prec9, d_new, w_new;
	logic signed [8:0] dpos, lead_s, zw, zc_s, w2, d2, trail_s;
	logic [6:0] dig7;
	logic [8:0] total;
	logic [6:0] cap_d;
	logic [6:0] ld_cnt;
	logic [7:0] emit_ch;
	logic emit_active, emit_fire, emit_drop, fin_fire, last_n;

	assign uc = ucode_rom(pc_q);
	assign in_stall = (uc.op != OP_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;

	assign wcl_d = (int'(field_width) > MAX_FIELD_WIDTH) ? 6'(MAX_FIELD_WIDTH) : field_width;

	assign dcmd.load = in_acc;
	assign dcmd.mul = (uc.op == OP_DIVM);
	assign dcmd.rem = (uc.op == OP_DIVR);
	assign rd_idx = run_q[3:0] - 4'd1;

	sdff_digits u_digits (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(dcmd),
		.value(value),
		.rd_idx(rd_idx),
		.ndig(ndig),
		.more(more),
		.rd_digit(rd_digit)
	);

	// run lengths
	assign pz = (prec_q == 7'sd0) && vz_q;
	assign pinc = neg_q && !prec_q[6] && (prec_q != 7'sd0);
	assign len_s = pz ? 9'sd0 : $signed({5'b0, ndig} + {8'b0, neg_q});
	assign prec9 = {{2{prec_q[6]}}, prec_q};
	assign d_new = prec9 + $signed({8'b0, pinc}) - len_s;
	assign w_new = $signed({3'b0, wcl_q}) - len_s - $signed({8'b0, plus_q && !neg_q});

	assign dpos = (d_q > 9'sd0) ? d_q : 9'sd0;
	assign lead_s = (!zero_q && !left_q && (w_q > 9'sd0) && (w_q > d_q)) ? (w_q - dpos) : 9'sd0;

	assign zw = (zero_q && (w_q > 9'sd0)) ? w_q : 9'sd0;
	assign zc_s = (zw > dpos) ? zw : dpos;
	assign w2 = w_q - zc_s;
	assign d2 = d_q - zc_s;
	assign trail_s = (left_q && (d2 <= 9'sd0) && (w2 > 9'sd0)) ? w2 : 9'sd0;

	assign signc = plus_q || neg_q;
	assign dig7 = len_nz_q ? {3'b0, ndig} : 7'd0;
	assign total = {8'b0, sp_q} + {2'b0, lead_q} + {8'b0, signc} + {2'b0, zc_q}
		+ {2'b0, dig7} + {2'b0, trail_q};
	assign cap_d = (total > 9'(MAX_RESULTS)) ? 7'(MAX_RESULTS) : total[6:0];

	always_comb begin
		case (uc.ld)
			SRC_SPACE: ld_cnt = {6'b0, sp_q};
			SRC_LEAD: ld_cnt = lead_q;
			SRC_SIGN: ld_cnt = {6'b0, signc};
			SRC_ZERO: ld_cnt = zc_q;
			SRC_DIGIT: ld_cnt = dig7;
			SRC_TRAIL: ld_cnt = trail_q;
			default: ld_cnt = 7'd0;
		endcase
	end

	always_comb begin
		case (uc.src)
			SRC_SPACE: emit_ch = CH_SPACE;
			SRC_LEAD: emit_ch = CH_SPACE;
			SRC_SIGN: emit_ch = neg_q ? CH_MINUS : CH_PLUS;
			SRC_ZERO: emit_ch = CH_ZERO;
			SRC_DIGIT: emit_ch = CH_ZERO + {4'b0, rd_digit};
			SRC_TRAIL: emit_ch = CH_SPACE;
			default: emit_ch = CH_SPACE;
		endcase
	end

	// characters past the result limit are counted off without a transfer
	assign emit_active = (uc.op == OP_EMIT) && (run_q != 7'd0);
	assign emit_fire = emit_active && (n_q < cap_q) && slot_free;
	assign emit_drop = emit_active && !(n_q < cap_q);
	assign fin_fire = (uc.op == OP_FIN) && (cap_q == 7'd0) && slot_free;
	assign last_n = ((n_q + 7'd1) == cap_q);

	always_comb begin
		case (uc.cond)
			COND_NEVER: taken = 1'b0;
			COND_NO_IN: taken = !in_acc;
			COND_MORE_DIG: taken = more;
			COND_RUN: taken = (run_q != 7'd0);
			COND_FIN_WAIT: taken = (cap_q == 7'd0) && !slot_free;
			default: taken = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
			n_q <= '0;
			cap_q <= '0;
			run_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= taken ? uc.jt : uc.jf;
			if (in_acc) begin
				n_q <= '0;
			end else if (emit_fire) begin
				n_q <= n_q + 7'd1;
			end
			if (uc.op == OP_TOT) begin
				cap_q <= cap_d;
			end
			if ((uc.op == OP_TOT) || ((uc.op == OP_EMIT) && (run_q == 7'd0))) begin
				run_q <= ld_cnt;
			end else if (emit_fire || emit_drop) begin
				run_q <= run_q - 7'd1;
			end
			if (emit_fire || fin_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			neg_q <= value[31];
			vz_q <= (value == 32'sd0);
			wcl_q <= wcl_d;
			prec_q <= precision;
			left_q <= flag_left_align;
			zero_q <= flag_zero_pad;
			plus_q <= flag_plus;
			space_q <= flag_space;
		end
		case (uc.op)
			OP_PREP: begin
				w_q <= w_new;
				d_q <= d_new;
				len_nz_q <= !pz;
			end
			OP_CNT1: begin
				sp_q <= space_q && !plus_q && !neg_q && (w_q <= 9'sd0);
				lead_q <= lead_s[6:0];
				w_q <= w_q - lead_s;
			end
			OP_CNT2: begin
				zc_q <= zc_s[6:0];
				trail_q <= trail_s[6:0];
			end
			default: begin
			end
		endcase
		if (emit_fire) begin
			out_char_q <= emit_ch;
			out_last_q <= last_n;
			out_empty_q <= 1'b0;
			out_cnt_q <= last_n ? (n_q + 7'd1) : 7'd0;
		end else if (fin_fire) begin
			out_char_q <= 8'd0;
			out_last_q <= 1'b1;
			out_empty_q <= 1'b1;
			out_cnt_q <= 7'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign character = out_char_q;
	assign is_last = out_last_q;
	assign is_empty = out_empty_q;
	assign char_count = out_cnt_q;

	`SDFF_ASSERT_IMP(a_count_within_cap, clk, arst_n, 1'b1, n_q <= cap_q, "emitted count beyond cap")
	`SDFF_ASSERT_NXT(a_accept_starts_divide, clk, arst_n, in_acc, pc_q == PC_DIVM, "accept did not start digit loop")
	`SDFF_ASSERT_IMP(a_digit_index_valid, clk, arst_n, (uc.op == OP_EMIT) && (uc.src == SRC_DIGIT) && (run_q != 7'd0), run_q <= 7'(ndig), "digit read past stored digits")

endmodule

// ===== verif/tb_signed_decimal_field_formatter_core.sv =====
// testbench for the signed decimal field formatter: random and directed items, self-checking
`timescale 1ns / 1ps

module tb_signed_decimal_field_formatter_core;
	import sdff_pkg::*;

	typedef struct {
		logic signed [31:0] value;
		logic [5:0] field_width;
		logic signed [6:0] precision;
		logic left_align;
		logic zero_pad;
		logic plus;
		logic space;
	} fmt_item_t;

	typedef struct {
		logic [7:0] ch;
		logic last;
		logic empty;
		logic [6:0] count;
	} fmt_char_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] value = '0;
	logic [5:0] field_width = '0;
	logic signed [6:0] precision = '0;
	logic flag_left_align = 1'b0;
	logic flag_zero_pad = 1'b0;
	logic flag_plus = 1'b0;
	logic flag_space = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] character;
	logic is_last;
	logic is_empty;
	logic [6:0] char_count;

	fmt_item_t pending_items[$];
	fmt_char_t expected_chars[$];
	fmt_item_t drv_item;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int err_count = 0;

	signed_decimal_field_formatter_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.value(value),
		.field_width(field_width),
		.precision(precision),
		.flag_left_align(flag_left_align),
		.flag_zero_pad(flag_zero_pad),
		.flag_plus(flag_plus),
		.flag_space(flag_space),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.character(character),
		.is_last(is_last),
		.is_empty(is_empty),
		.char_count(char_count)
	);

	always #10 clk = ~clk;

	// printf %d text of one item, appended to the expected characters
	function automatic void format_decimal_text(input fmt_item_t it);
		logic [31:0] raw;
		logic [31:0] mag;
		logic [31:0] m;
		logic [3:0] digs[10];
		logic [7:0] text[$];
		fmt_char_t c;
		bit neg;
		int w;
		int d;
		int ndig;
		int len;
		int i;
		raw = it.value;
		neg = raw[31];
		mag = neg ? (32'd0 - raw) : raw;
		w = int'(it.field_width);
		if (w > MAX_FIELD_WIDTH_DEF) begin
			w = MAX_FIELD_WIDTH_DEF;
		end
		d = int'(it.precision);
		m = mag;
		ndig = 0;
		do begin
			digs[ndig] = 4'(m % 10);
			ndig++;
			m = m / 10;
		end while (m != 0 && ndig < NDIG_MAX);
		len = ndig + (neg ? 1 : 0);
		if (d == 0 && raw == 0) begin
			len = 0;
		end
		if (neg && d > 0) begin
			d++;
		end
		w -= len;
		d -= len;
		if (it.plus && !neg) begin
			w--;
		end
		// blank only when no width remains
		if (it.space && !it.plus && w <= 0 && !neg) begin
			text.push_back(CH_SPACE);
		end
		while (w > d && !it.zero_pad && !it.left_align && w > 0) begin
			text.push_back(CH_SPACE);
			w--;
		end
		if (it.plus && !neg) begin
			text.push_back(CH_PLUS);
		end
		if (neg) begin
			text.push_back(CH_MINUS);
		end
		while ((it.zero_pad && w > 0) || d > 0) begin
			text.push_back(CH_ZERO);
			w--;
			d--;
		end
		if (len != 0) begin
			for (i = ndig - 1; i >= 0; i--) begin
				text.push_back(CH_ZERO + 8'(digs[i]));
			end
		end
		while (it.left_align && d <= 0 && w > 0) begin
			text.push_back(CH_SPACE);
			w--;
		end
		while (text.size() > MAX_RESULTS) begin
			void'(text.pop_back());
		end
		if (text.size() == 0) begin
			c = '{ch: 8'd0, last: 1'b1, empty: 1'b1, count: 7'd0};
			expected_chars.push_back(c);
		end else begin
			for (i = 0; i < text.size(); i++) begin
				c.ch = text[i];
				c.last = (i == text.size() - 1);
				c.empty = 1'b0;
				c.count = c.last ? 7'(text.size()) : 7'd0;
				expected_chars.push_back(c);
			end
		end
	endfunction

	task automatic add_item(input logic [31:0] v, input int w, input int p,
			input bit l, input bit z, input bit pl, input bit s);
		fmt_item_t it;
		it.value = v;
		it.field_width = 6'(w);
		it.precision = 7'(p);
		it.left_align = l;
		it.zero_pad = z;
		it.plus = pl;
		it.space = s;
		pending_items.push_back(it);
	endtask

	function automatic logic [31:0] pick_value();
		logic [31:0] v;
		int k;
		k = $urandom_range(9);
		case (k)
			0, 1, 2: begin
				v = $urandom_range(999);
			end
			3, 4, 5: begin
				v = $urandom;
			end
			6: begin
				v = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			end
			7: begin
				v = 32'd0;
			end
			default: begin
				v = 32'd1;
				repeat ($urandom_range(9)) v = v * 10;
				v = v - 32'($urandom_range(1));
			end
		endcase
		if (k != 6 && $urandom_range(1)) begin
			v = 32'd0 - v;
		end
		return v;
	endfunction

	task automatic add_random_item();
		int w;
		int p;
		int k;
		w = $urandom_range(3) == 0 ? $urandom_range(63) : $urandom_range(12);
		k = $urandom_range(3);
		if (k == 0) begin
			p = -1;
		end else if (k == 1) begin
			p = $urandom_range(127);
		end else begin
			p = $urandom_range(12);
		end
		add_item(pick_value(), w, p, 1'($urandom_range(1)), 1'($urandom_range(1)),
			1'($urandom_range(1)), 1'($urandom_range(1)));
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) begin
				format_decimal_text(drv_item);
			end
			if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				drv_item = pending_items.pop_front();
				in_valid <= 1'b1;
				value <= drv_item.value;
				field_width <= drv_item.field_width;
				precision <= drv_item.precision;
				flag_left_align <= drv_item.left_align;
				flag_zero_pad <= drv_item.zero_pad;
				flag_plus <= drv_item.plus;
				flag_space <= drv_item.space;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		fmt_char_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_chars.size() == 0) begin
					if (err_count < 10) begin
						$display("unexpected transfer: char %h last %b empty %b count %0d",
							character, is_last, is_empty, char_count);
					end
					err_count++;
				end else begin
					e = expected_chars.pop_front();
					if (character !== e.ch || is_last !== e.last || is_empty !== e.empty
							|| char_count !== e.count) begin
						if (err_count < 10) begin
							$display("mismatch: exp %h/%b/%b/%0d got %h/%b/%b/%0d",
								e.ch, e.last, e.empty, e.count,
								character, is_last, is_empty, char_count);
						end
						err_count++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	initial begin
		int ph;
		int send_pct[4];
		int recv_pct[4];
		send_pct = '{0, 88, 0, 11};
		recv_pct = '{0, 0, 88, 11};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		for (ph = 0; ph < 4; ph++) begin
			send_idle_pct = send_pct[ph];
			recv_stall_pct = recv_pct[ph];
			if (ph == 0) begin
				add_item(32'd0, 0, -1, 0, 0, 0, 0);
				add_item(32'd0, 0, 0, 0, 0, 0, 0);
				add_item(32'd0, 5, 0, 0, 0, 0, 0);
				add_item(32'd0, 0, 0, 0, 0, 1, 0);
				add_item(32'd0, 0, 0, 0, 0, 0, 1);
				add_item(32'h8000_0000, 0, -1, 0, 0, 0, 0);
				add_item(32'h7FFF_FFFF, 0, -1, 0, 0, 1, 0);
				add_item(32'hFFFF_FFFF, 8, -1, 0, 1, 0, 0);
				add_item(32'd42, 8, 5, 0, 1, 0, 0);
				add_item(32'd42, 8, -1, 1, 0, 0, 0);
				add_item(32'd42, 8, -1, 1, 1, 0, 0);
				add_item(32'd42, 3, -1, 0, 0, 0, 1);
				add_item(32'd42, 2, -1, 0, 0, 0, 1);
				add_item(32'd42, 6, -1, 0, 0, 0, 1);
				add_item(-32'sd42, 6, 4, 0, 0, 0, 0);
				add_item(32'd7, 63, -1, 0, 1, 0, 0);
				add_item(32'h8000_0000, 63, 62, 1, 0, 0, 0);
				add_item(-32'sd5, 0, 63, 0, 0, 0, 0);
				add_item(32'd5, 0, 63, 0, 0, 1, 0);
				add_item(32'd5, 0, 63, 0, 0, 0, 1);
				add_item(32'd123, 10, -64, 0, 0, 0, 0);
				add_item(32'd99, 63, -1, 1, 0, 1, 0);
				add_item(32'd0, 63, 0, 1, 0, 0, 1);
				add_item(32'd1000000000, 12, 11, 1, 1, 1, 1);
			end
			repeat (34) add_random_item();
			// checked away from the rising edge so queue and valid are settled
			while (pending_items.size() != 0 || in_valid || expected_chars.size() != 0) begin
				@(negedge clk);
			end
		end
		repeat (120) @(posedge clk);
		if (err_count == 0 && expected_chars.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
